[rtl/fcp_pkg.sv]
// Types, stage records and the divider step shared by the cone projection files.
package fcp_pkg;

  localparam int SqrtSteps = 32;
  localparam int DivSteps  = 31;
  localparam logic [30:0] LimitMax = 31'h7FFF_FFFF;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [30:0] fz;
  } side_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] v;
    logic [33:0] rem;
    logic [31:0] root;
    logic [30:0] limit;
    logic [31:0] ax;
    logic [31:0] ay;
    side_t       side;
  } sqrt_stage_t;

  typedef struct packed {
    logic [31:0] r;
    logic [30:0] n;
    logic [30:0] q;
  } div_lane_t;

  typedef struct packed {
    logic        valid;
    logic        scale;
    logic [31:0] d;
    div_lane_t   lx;
    div_lane_t   ly;
    side_t       side;
  } div_stage_t;

  function automatic div_lane_t div_step(div_lane_t l, logic [31:0] d);
    logic [32:0] t;
    div_lane_t   o;
    t = {l.r, l.n[30]};
    o.n = {l.n[29:0], 1'b0};
    if (t >= {1'b0, d}) begin
      o.r = 32'(t - {1'b0, d});
      o.q = {l.q[29:0], 1'b1};
    end else begin
      o.r = t[31:0];
      o.q = {l.q[29:0], 1'b0};
    end
    return o;
  endfunction

endpackage

[rtl/fcp_if.sv]
// Contact and projection channel interfaces.
interface fcp_contact_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] force_x;
  logic signed [31:0] force_y;
  logic signed [31:0] force_z;
  logic        [17:0] friction_coef;
  modport source (output valid, force_x, force_y, force_z, friction_coef, input ready);
  modport sink (input valid, force_x, force_y, force_z, friction_coef, output ready);
endinterface

interface fcp_proj_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] proj_x;
  logic signed [31:0] proj_y;
  logic        [30:0] proj_z;
  modport source (output valid, proj_x, proj_y, proj_z, input ready);
  modport sink (input valid, proj_x, proj_y, proj_z, output ready);
endinterface

[rtl/friction_cone_projection_top.sv]
// Friction cone projection: squares, square root cell chain, scale, divider cell chain.
//
//  channel   dir  word
//  contact   in   force_x, force_y, force_z, friction_coef
//  proj      out  proj_x, proj_y, proj_z
//
//  One word accepted per cycle unless the output holds; 3 front stages, 32 root
//  cells, product stage, 31 divider cells, output register.
//  Most of the stages are in the two bit-per-cell chains.
//  The whole pipeline holds while a result sits unaccepted at the output.
//  rst is synchronous and clears only the valid flags.
module friction_cone_projection_top
  import fcp_pkg::*;
(
  input logic          clk,
  input logic          rst,
  fcp_contact_if.sink  contact,
  fcp_proj_if.source   proj
);

  logic en;
  assign en = !proj.valid || proj.ready;
  assign contact.ready = en;

  typedef struct packed {
    logic        valid;
    logic [31:0] ax;
    logic [31:0] ay;
    logic [17:0] coef;
    side_t       side;
  } s1_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] sqx;
    logic [63:0] sqy;
    logic [48:0] lp;
    logic [31:0] ax;
    logic [31:0] ay;
    side_t       side;
  } s2_t;

  typedef struct packed {
    logic        valid;
    logic        scale;
    logic [31:0] d;
    logic [61:0] px;
    logic [61:0] py;
    side_t       side;
  } ps_t;

  s1_t         s1;
  s2_t         s2;
  ps_t         ps;
  sqrt_stage_t sq [0:SqrtSteps];
  div_stage_t  dv [0:DivSteps];
  sqrt_stage_t sq0;
  sqrt_stage_t sq0_next;
  div_stage_t  dv0;
  ps_t         ps_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (en) begin
      s1.valid   <= contact.valid;
      s1.ax      <= contact.force_x[31] ? 32'(-contact.force_x) : contact.force_x;
      s1.ay      <= contact.force_y[31] ? 32'(-contact.force_y) : contact.force_y;
      s1.coef    <= contact.friction_coef;
      s1.side.x  <= contact.force_x;
      s1.side.y  <= contact.force_y;
      s1.side.fz <= contact.force_z[31] ? 31'd0 : contact.force_z[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (en) begin
      s2.valid <= s1.valid;
      s2.sqx   <= 64'(s1.ax) * 64'(s1.ax);
      s2.sqy   <= 64'(s1.ay) * 64'(s1.ay);
      s2.lp    <= 49'(s1.coef) * 49'(s1.side.fz);
      s2.ax    <= s1.ax;
      s2.ay    <= s1.ay;
      s2.side  <= s1.side;
    end
  end

  always_comb begin
    sq0_next.valid = s2.valid;
    sq0_next.v     = s2.sqx + s2.sqy;
    sq0_next.rem   = '0;
    sq0_next.root  = '0;
    sq0_next.limit = (s2.lp[48:16] > {2'b00, LimitMax}) ? LimitMax : s2.lp[46:16];
    sq0_next.ax    = s2.ax;
    sq0_next.ay    = s2.ay;
    sq0_next.side  = s2.side;
  end

  always_ff @(posedge clk) begin
    if (rst) sq0.valid <= 1'b0;
    else if (en) sq0 <= sq0_next;
  end

  assign sq[0] = sq0;

  for (genvar i = 0; i < SqrtSteps; i++) begin : g_sqrt
    fcp_sqrt_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (sq[i]),
      .d_out (sq[i+1])
    );
  end

  always_comb begin
    ps_next.valid = sq[SqrtSteps].valid;
    ps_next.scale = sq[SqrtSteps].root > {1'b0, sq[SqrtSteps].limit};
    ps_next.d     = sq[SqrtSteps].root;
    ps_next.px    = 62'(sq[SqrtSteps].limit) * 62'(sq[SqrtSteps].ax);
    ps_next.py    = 62'(sq[SqrtSteps].limit) * 62'(sq[SqrtSteps].ay);
    ps_next.side  = sq[SqrtSteps].side;
  end

  always_ff @(posedge clk) begin
    if (rst) ps.valid <= 1'b0;
    else if (en) ps <= ps_next;
  end

  always_comb begin
    dv0.valid = ps.valid;
    dv0.scale = ps.scale;
    dv0.d     = ps.d;
    dv0.lx.r  = {1'b0, ps.px[61:31]};
    dv0.lx.n  = ps.px[30:0];
    dv0.lx.q  = '0;
    dv0.ly.r  = {1'b0, ps.py[61:31]};
    dv0.ly.n  = ps.py[30:0];
    dv0.ly.q  = '0;
    dv0.side  = ps.side;
  end

  assign dv[0] = dv0;

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    fcp_div_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (dv[j]),
      .d_out (dv[j+1])
    );
  end

  logic [31:0] qx_s;
  logic [31:0] qy_s;

  always_comb begin
    qx_s = dv[DivSteps].side.x[31] ? 32'(-{1'b0, dv[DivSteps].lx.q})
                                   : {1'b0, dv[DivSteps].lx.q};
    qy_s = dv[DivSteps].side.y[31] ? 32'(-{1'b0, dv[DivSteps].ly.q})
                                   : {1'b0, dv[DivSteps].ly.q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proj.valid <= 1'b0;
    end else if (en) begin
      proj.valid  <= dv[DivSteps].valid;
      proj.proj_x <= dv[DivSteps].scale ? qx_s : dv[DivSteps].side.x;
      proj.proj_y <= dv[DivSteps].scale ? qy_s : dv[DivSteps].side.y;
      proj.proj_z <= dv[DivSteps].side.fz;
    end
  end

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    contact.valid && contact.ready |=> s1.valid)
    else $error("accepted word did not enter the pipeline");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !proj.valid)
    else $error("output valid after reset");

  a_scale_nonzero: assert property (@(posedge clk) disable iff (rst)
    ps.valid && ps.scale |-> ps.d != 32'd0)
    else $error("scaling with zero magnitude");

endmodule

[rtl/fcp_sqrt_cell.sv]
// One bit of the magnitude square root per cell.
module fcp_sqrt_cell
  import fcp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  sqrt_stage_t d_in,
  output sqrt_stage_t d_out
);

  logic [35:0] t;
  logic [35:0] trial;
  sqrt_stage_t nxt;

  always_comb begin
    t     = {d_in.rem, d_in.v[63:62]};
    trial = {2'b00, d_in.root, 2'b01};
    nxt   = d_in;
    nxt.v = {d_in.v[61:0], 2'b00};
    if (t >= trial) begin
      nxt.rem  = 34'(t - trial);
      nxt.root = {d_in.root[30:0], 1'b1};
    end else begin
      nxt.rem  = t[33:0];
      nxt.root = {d_in.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) d_out.valid <= 1'b0;
    else if (en) d_out <= nxt;
  end

endmodule

[rtl/fcp_div_cell.sv]
// One quotient bit for both tangential lanes per cell.
module fcp_div_cell
  import fcp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  div_stage_t d_in,
  output div_stage_t d_out
);

  div_stage_t nxt;

  always_comb begin
    nxt    = d_in;
    nxt.lx = div_step(d_in.lx, d_in.d);
    nxt.ly = div_step(d_in.ly, d_in.d);
  end

  always_ff @(posedge clk) begin
    if (rst) d_out.valid <= 1'b0;
    else if (en) d_out <= nxt;
  end

endmodule
